[rtl/core/sdw_pkg.sv]
// Shared types and constants for the sequence duplicate window block.
// No dependencies; imported by the top level.
package sdw_pkg;

  localparam int MAX_WINDOW = 1024;

  // field and register widths
  localparam int SEQ_W     = 32;
  localparam int SEQB_W    = 6;
  localparam int WSIZE_W   = 11;
  localparam int VERDICT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 8;

  // bitmap ring, stored as words in a RAM
  localparam int PTR_W     = $clog2(MAX_WINDOW);
  localparam int WORD_W    = (MAX_WINDOW >= 64) ? 32 : MAX_WINDOW / 2;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = MAX_WINDOW / WORD_W;
  localparam int WADDR_W   = PTR_W - BIT_W;
  localparam int CNT_W     = $clog2(NUM_WORDS + 2);
  localparam int WINC_W    = PTR_W + 1;

  // register reset values
  localparam logic [SEQB_W-1:0]  SEQ_BITS_RST    = SEQB_W'(16);
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = WSIZE_W'(1024);
  localparam logic [SEQ_W-1:0]   PAST_LIMIT_RST  = SEQ_W'(32768);

  // clamp bounds of the sequence width
  localparam logic [SEQB_W-1:0] SEQ_BITS_MIN = SEQB_W'(8);
  localparam logic [SEQB_W-1:0] SEQ_BITS_MAX = SEQB_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_BITS    = 2'd0,
    CFG_WINDOW_SIZE = 2'd1,
    CFG_PAST_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [VERDICT_W-1:0] {
    V_FIRST       = 3'd0,
    V_AHEAD       = 3'd1,
    V_LATE_NEW    = 3'd2,
    V_LATE_DUP    = 3'd3,
    V_TOO_OLD     = 3'd4,
    V_ANCIENT     = 3'd5,
    V_REPEAT_HIGH = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLASS,
    ST_SRD,
    ST_SWR,
    ST_TST,
    ST_PUSH
  } state_e;

endpackage

[rtl/core/sdw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sequence_duplicate_window_top.sv]
// An item is taken in ST_IDLE, then passes ST_DIFF and ST_CLASS; first, repeat, too-old and
// restart verdicts go straight to ST_PUSH, a late packet goes through ST_TST, and a forward
// slide walks ST_SRD and ST_SWR once per bitmap RAM word touched (about d/32 + 1, d = distance
// ahead). ST_PUSH loads the output register. One item at a time: no new input is taken until
// the result is in the output register, and ST_PUSH waits while that register is full.
// Reset clears control state and the per-word valid bits; no clearing pass. Uses sdw_pkg, sdw_ram.
module sequence_duplicate_window_top
  import sdw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SEQ_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SEQ_W-1:0]     s_axis_tdata,   // [31:0] seq
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata    // [0] is_dup, [3:1] verdict, [7:4] zero
);

  // configuration
  logic [SEQB_W-1:0]  seq_bits_q;
  logic [WSIZE_W-1:0] window_size_q;
  logic [SEQ_W-1:0]   past_limit_q;

  // state
  state_e              state_q, state_d;
  logic                have_any_q;
  logic [SEQ_W-1:0]    highest_q;
  logic [PTR_W-1:0]    h_q;
  logic [NUM_WORDS-1:0] wvld_q;

  // per-item working registers
  logic [SEQ_W-1:0]    seq_q, mask_q, half_q, lim_q, d_q, b_q;
  logic [WINC_W-1:0]   win_q;
  logic                gt_q;
  logic [PTR_W-1:0]    start_q, hn_q, tpos_q;
  logic [WADDR_W-1:0]  wptr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rd_vld_q;
  logic                res_dup_q;
  verdict_e            res_verdict_q;

  // output register
  logic                m_valid_q;
  logic                m_dup_q;
  verdict_e            m_verdict_q;

  // clamped configuration
  logic [SEQB_W-1:0]   bits_c;
  logic [SEQ_W-1:0]    mask_c, half_c, win32_c, lim_c;

  always_comb begin
    if (seq_bits_q < SEQ_BITS_MIN) begin
      bits_c = SEQ_BITS_MIN;
    end else if (seq_bits_q > SEQ_BITS_MAX) begin
      bits_c = SEQ_BITS_MAX;
    end else begin
      bits_c = seq_bits_q;
    end
    mask_c = {SEQ_W{1'b1}} >> (SEQ_BITS_MAX - bits_c);
    half_c = SEQ_W'(1) << (bits_c - SEQB_W'(1));
    win32_c = SEQ_W'(window_size_q);
    if (win32_c == '0) begin
      win32_c = SEQ_W'(1);
    end
    if (win32_c > SEQ_W'(MAX_WINDOW)) begin
      win32_c = SEQ_W'(MAX_WINDOW);
    end
    if (win32_c > half_c) begin
      win32_c = half_c;
    end
  end

  // past limit clamp uses the registered window and half range
  always_comb begin
    lim_c = past_limit_q;
    if (lim_c < SEQ_W'(win_q)) begin
      lim_c = SEQ_W'(win_q);
    end
    if (lim_c > half_q) begin
      lim_c = half_q;
    end
  end

  // classification of the item
  logic     ahead, cls_restart, cls_slide, cls_test;
  logic     cls_dup;
  verdict_e cls_verdict;

  always_comb begin
    ahead       = (d_q < half_q) || ((d_q == half_q) && gt_q);
    cls_restart = 1'b0;
    cls_slide   = 1'b0;
    cls_test    = 1'b0;
    cls_dup     = 1'b0;
    cls_verdict = V_FIRST;
    if (!have_any_q) begin
      cls_restart = 1'b1;
      cls_verdict = V_FIRST;
    end else if (d_q == '0) begin
      cls_dup     = 1'b1;
      cls_verdict = V_REPEAT_HIGH;
    end else if (ahead) begin
      cls_verdict = V_AHEAD;
      if (d_q < SEQ_W'(win_q)) begin
        cls_slide = 1'b1;
      end else begin
        cls_restart = 1'b1;
      end
    end else if (b_q < SEQ_W'(win_q)) begin
      cls_test = 1'b1;
    end else if (b_q < lim_q) begin
      cls_dup     = 1'b1;
      cls_verdict = V_TOO_OLD;
    end else begin
      cls_restart = 1'b1;
      cls_verdict = V_ANCIENT;
    end
  end

  // slide setup values
  logic [PTR_W-1:0]  start_c, hn_c, tpos_c;
  logic [PTR_W:0]    tot_c;
  logic [CNT_W-1:0]  cnt_c;

  always_comb begin
    start_c = h_q + PTR_W'(1);
    hn_c    = h_q + d_q[PTR_W-1:0];
    tpos_c  = h_q - b_q[PTR_W-1:0];
    tot_c   = (PTR_W+1)'(start_c[BIT_W-1:0]) + (PTR_W+1)'(d_q[PTR_W-1:0])
              - (PTR_W+1)'(1);
    cnt_c   = CNT_W'(tot_c >> BIT_W) + CNT_W'(1);
  end

  // RAM word handling
  logic [WORD_W-1:0] rdata, word_rd, clr_mask, set_mask, test_bit;
  logic              bit_seen;

  assign word_rd  = rd_vld_q ? rdata : '0;
  assign test_bit = WORD_W'(1) << tpos_q[BIT_W-1:0];
  assign bit_seen = |(word_rd & test_bit);

  always_comb begin
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] rel;
    for (int k = 0; k < WORD_W; k++) begin
      pos         = {wptr_q, BIT_W'(k)};
      rel         = pos - start_q;
      clr_mask[k] = rel < d_q[PTR_W-1:0];
      set_mask[k] = pos == hn_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF:  state_d = ST_CLASS;
      ST_CLASS: begin
        if (cls_slide) begin
          state_d = ST_SRD;
        end else if (cls_test) begin
          state_d = ST_TST;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_SRD:   state_d = ST_SWR;
      ST_SWR: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_TST:   state_d = ST_PUSH;
      ST_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // RAM and handshake controls
  logic               ram_we, ram_re;
  logic [WADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata;

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = wptr_q;
    ram_raddr     = wptr_q;
    ram_wdata     = '0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_CLASS: begin
        if (cls_restart) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = WORD_W'(1);
        end else if (cls_test) begin
          ram_re    = 1'b1;
          ram_raddr = tpos_c[PTR_W-1:BIT_W];
        end
      end
      ST_SRD:   ram_re = 1'b1;
      ST_SWR: begin
        ram_we    = 1'b1;
        ram_wdata = (word_rd & ~clr_mask) | set_mask;
      end
      ST_TST: begin
        ram_we    = !bit_seen;
        ram_waddr = tpos_q[PTR_W-1:BIT_W];
        ram_wdata = word_rd | test_bit;
      end
      default: ;
    endcase
  end

  sdw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seq_bits_q    <= SEQ_BITS_RST;
      window_size_q <= WINDOW_SIZE_RST;
      past_limit_q  <= PAST_LIMIT_RST;
      have_any_q    <= 1'b0;
      wvld_q        <= '0;
      cnt_q         <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SEQ_BITS: begin
            seq_bits_q <= cfg_wdata_i[SEQB_W-1:0];
            have_any_q <= 1'b0;
          end
          CFG_WINDOW_SIZE: begin
            window_size_q <= cfg_wdata_i[WSIZE_W-1:0];
            have_any_q    <= 1'b0;
          end
          CFG_PAST_LIMIT: begin
            past_limit_q <= cfg_wdata_i;
            have_any_q   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == ST_CLASS && cls_restart) begin
        have_any_q <= 1'b1;
        wvld_q     <= NUM_WORDS'(1);
      end
      if (state_q == ST_CLASS) begin
        cnt_q <= cnt_c;
      end else if (state_q == ST_SWR) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (ram_we && state_q != ST_CLASS) begin
        wvld_q[ram_waddr] <= 1'b1;
      end
      if (state_q == ST_PUSH && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          seq_q  <= s_axis_tdata & mask_c;
          mask_q <= mask_c;
          half_q <= half_c;
          win_q  <= WINC_W'(win32_c);
        end
      end
      ST_DIFF: begin
        d_q   <= (seq_q - highest_q) & mask_q;
        b_q   <= (highest_q - seq_q) & mask_q;
        gt_q  <= seq_q > highest_q;
        lim_q <= lim_c;
      end
      ST_CLASS: begin
        res_dup_q     <= cls_dup;
        res_verdict_q <= cls_verdict;
        start_q       <= start_c;
        hn_q          <= hn_c;
        tpos_q        <= tpos_c;
        wptr_q        <= start_c[PTR_W-1:BIT_W];
        if (cls_restart) begin
          h_q       <= '0;
          highest_q <= seq_q;
        end
      end
      ST_SWR: begin
        wptr_q <= wptr_q + WADDR_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          h_q       <= hn_q;
          highest_q <= seq_q;
        end
      end
      ST_TST: begin
        res_dup_q     <= bit_seen;
        res_verdict_q <= bit_seen ? V_LATE_DUP : V_LATE_NEW;
      end
      ST_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_dup_q     <= res_dup_q;
          m_verdict_q <= res_verdict_q;
        end
      end
      default: ;
    endcase
    if (ram_re) begin
      rd_vld_q <= wvld_q[ram_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_W - VERDICT_W - 1)'(0), m_verdict_q, m_dup_q};

  // a slide walk never runs with an empty word count
  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWR |-> cnt_q != '0)
    else $error("slide walk with zero word count");

  // restart leaves exactly the head word valid
  a_restart_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLASS && cls_restart) |=> $onehot(wvld_q))
    else $error("restart did not leave a single valid word");

  // every finished item has established a window
  a_have_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUSH |-> have_any_q)
    else $error("result without an established window");

  // duplicate flag agrees with the verdict
  a_dup_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_dup_q == (m_verdict_q == V_LATE_DUP || m_verdict_q == V_TOO_OLD
                               || m_verdict_q == V_REPEAT_HIGH)))
    else $error("is_dup inconsistent with verdict");

endmodule
